// ===== rtl/qhs_pkg.sv =====
// Shared types, constants and helper functions for the quad half-step stepper block.
`timescale 1ns / 1ps

package qhs_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int MOT_W      = 2;
  localparam int PEND_W     = 16;
  localparam int PHASE_W    = 3;
  localparam int COIL_W     = 4;
  localparam int HPH_W      = 4;

  typedef logic signed [PEND_W-1:0] pend_t;
  typedef logic [PHASE_W-1:0]       phase_t;
  typedef logic [COIL_W-1:0]        coil_t;
  typedef logic [HPH_W-1:0]         hph_t;
  typedef logic [MOT_W-1:0]         mot_id_t;

  typedef pend_t  pend_arr_t  [NUM_MOTORS];
  typedef phase_t phase_arr_t [NUM_MOTORS];
  typedef coil_t  coil_arr_t  [NUM_MOTORS];

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } op_t;

  // Homing run phases: idle, first seek phase, final settle phase.
  localparam hph_t HPH_IDLE  = 4'd0;
  localparam hph_t HPH_FIRST = 4'd1;
  localparam hph_t HPH_LAST  = 4'd8;

  localparam pend_t START_PRELOAD = 16'sd500;

  // Control from the homing sequencer to the motor step unit.
  typedef struct packed {
    logic    pass;       // run the normal step pass over all motors
    logic    drive;      // one homing step on a single motor
    mot_id_t drive_id;
    logic    drive_fwd;
  } step_ctl_t;

  function automatic coil_t coil_pattern(input phase_t ph);
    coil_t c;
    case (ph)
      3'd0:    c = 4'b0001;
      3'd1:    c = 4'b0011;
      3'd2:    c = 4'b0010;
      3'd3:    c = 4'b0110;
      3'd4:    c = 4'b0100;
      3'd5:    c = 4'b1100;
      3'd6:    c = 4'b1000;
      default: c = 4'b1001;
    endcase
    return c;
  endfunction

  // Offset applied to a motor once its sensor reports home.
  function automatic pend_t seek_offset(input mot_id_t k);
    pend_t v;
    case (k)
      2'd0:    v = -16'sd160;
      2'd1:    v = -16'sd5450;
      2'd2:    v = 16'sd0;
      default: v = 16'sd200;
    endcase
    return v;
  endfunction

  // Preload queued on the following motor after motor k has settled.
  function automatic pend_t next_preload(input mot_id_t k);
    pend_t v;
    case (k)
      2'd0:    v = 16'sd500;
      2'd1:    v = 16'sd500;
      2'd2:    v = -16'sd500;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic pend_t sat_add(input pend_t a, input pend_t b);
    logic signed [PEND_W:0] s;
    pend_t r;
    s = {a[PEND_W-1], a} + {b[PEND_W-1], b};
    if (s > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (s < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = pend_t'(s[PEND_W-1:0]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/qhs_homing.sv =====
// Homing sequencer: walks the homing phases for one tick, letting transitions fall through.
`timescale 1ns / 1ps

module qhs_homing (
  input  qhs_pkg::hph_t      hph_cur,
  input  qhs_pkg::pend_arr_t pend_cur,
  input  logic [3:0]         home_sensors,
  output qhs_pkg::hph_t      hph_next,
  output qhs_pkg::pend_arr_t pend_next,
  output qhs_pkg::step_ctl_t ctl,
  output logic               done
);
  import qhs_pkg::*;

  mot_id_t k;

  // Each phase either stops the walk (step pass, homing step, finish) or advances
  // the phase, so the next iteration picks it up within the same tick.
  always_comb begin
    hph_next  = hph_cur;
    pend_next = pend_cur;
    ctl       = '0;
    done      = 1'b0;
    k         = '0;
    for (int p = 1; p <= int'(HPH_LAST); p++) begin
      if (hph_next == HPH_W'(p)) begin
        k = MOT_W'((p - 1) >> 1);
        if (pend_next[k] != '0) begin
          ctl.pass = 1'b1;
        end else if ((p & 1) != 0) begin
          if (home_sensors[k]) begin
            ctl.drive     = 1'b1;
            ctl.drive_id  = k;
            ctl.drive_fwd = (k == mot_id_t'(NUM_MOTORS - 1));
          end else begin
            hph_next     = hph_next + hph_t'(1);
            pend_next[k] = sat_add(pend_next[k], seek_offset(k));
          end
        end else if (HPH_W'(p) == HPH_LAST) begin
          hph_next = HPH_IDLE;
          done     = 1'b1;
        end else begin
          pend_next[k + mot_id_t'(1)] = sat_add(pend_next[k + mot_id_t'(1)], next_preload(k));
          hph_next = hph_next + hph_t'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/qhs_motor.sv =====
// Motor step unit: drives coils, advances phases and counts off pending steps.
`timescale 1ns / 1ps

module qhs_motor (
  input  qhs_pkg::step_ctl_t  ctl,
  input  qhs_pkg::pend_arr_t  pend_in,
  input  qhs_pkg::phase_arr_t phase_in,
  input  qhs_pkg::coil_arr_t  coil_in,
  output qhs_pkg::pend_arr_t  pend_out,
  output qhs_pkg::phase_arr_t phase_out,
  output qhs_pkg::coil_arr_t  coil_out,
  output logic [3:0]          stepped
);
  import qhs_pkg::*;

  logic [NUM_MOTORS-1:0] go;
  logic [NUM_MOTORS-1:0] fwd;

  always_comb begin
    for (int m = 0; m < NUM_MOTORS; m++) begin
      pend_out[m] = pend_in[m];
      go[m]       = 1'b0;
      fwd[m]      = 1'b0;
      if (ctl.drive && ctl.drive_id == MOT_W'(m)) begin
        // Homing steps leave the pending count alone.
        go[m]  = 1'b1;
        fwd[m] = ctl.drive_fwd;
      end else if (ctl.pass && pend_in[m] != '0) begin
        go[m]  = 1'b1;
        fwd[m] = !pend_in[m][PEND_W-1];
        if (fwd[m]) begin
          pend_out[m] = pend_in[m] - pend_t'(1);
        end else begin
          pend_out[m] = pend_in[m] + pend_t'(1);
        end
      end
      if (go[m]) begin
        coil_out[m]  = coil_pattern(phase_in[m]);
        phase_out[m] = fwd[m] ? phase_in[m] + phase_t'(1) : phase_in[m] - phase_t'(1);
      end else begin
        coil_out[m]  = coil_in[m];
        phase_out[m] = phase_in[m];
      end
    end
    stepped = go;
  end

endmodule

// ===== rtl/quad_half_step_stepper_homing.sv =====
// An accepted item's result is presented in the cycle after its transfer.
// Throughput: one item per cycle while the input is not stalled; the whole update is one combinational pass
// from the state registers to the result register.
// The input stalls only while a finished result waits and the output is stalled.
// Synchronous reset clears all step counts, phases and coil latches, and leaves homing idle.
`timescale 1ns / 1ps

module quad_half_step_stepper_homing (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [1:0]  motor_id,
  input  logic signed [15:0] step_count,
  input  logic [3:0]  home_sensors,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  coils_m1,
  output logic [3:0]  coils_m2,
  output logic [3:0]  coils_m3,
  output logic [3:0]  coils_m4,
  output logic [3:0]  stepped,
  output logic        homing_busy,
  output logic        init_done
);
  import qhs_pkg::*;

  pend_arr_t  pending;
  pend_arr_t  pending_next;
  phase_arr_t phase_index;
  phase_arr_t phase_index_next;
  coil_arr_t  coil_latch;
  coil_arr_t  coil_latch_next;
  hph_t       homing_phase;
  hph_t       homing_phase_next;
  logic [3:0] stepped_next;
  logic       init_done_next;

  hph_t       hm_hph;
  pend_arr_t  hm_pend;
  step_ctl_t  hm_ctl;
  logic       hm_done;
  step_ctl_t  tick_ctl;
  pend_arr_t  mot_pend;
  phase_arr_t mot_phase;
  coil_arr_t  mot_coil;
  logic [3:0] mot_stepped;
  logic       in_xfer;

  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  qhs_homing u_homing (
    .hph_cur      (homing_phase),
    .pend_cur     (pending),
    .home_sensors (home_sensors),
    .hph_next     (hm_hph),
    .pend_next    (hm_pend),
    .ctl          (hm_ctl),
    .done         (hm_done)
  );

  // Outside a homing run every tick is a plain step pass.
  always_comb begin
    tick_ctl = hm_ctl;
    if (homing_phase == HPH_IDLE) begin
      tick_ctl.pass = 1'b1;
    end
  end

  qhs_motor u_motor (
    .ctl       (tick_ctl),
    .pend_in   (hm_pend),
    .phase_in  (phase_index),
    .coil_in   (coil_latch),
    .pend_out  (mot_pend),
    .phase_out (mot_phase),
    .coil_out  (mot_coil),
    .stepped   (mot_stepped)
  );

  always_comb begin
    pending_next      = pending;
    phase_index_next  = phase_index;
    coil_latch_next   = coil_latch;
    homing_phase_next = homing_phase;
    stepped_next      = '0;
    init_done_next    = 1'b0;
    case (op)
      OP_MOVE: begin
        pending_next[motor_id] = sat_add(pending[motor_id], step_count);
      end
      OP_TICK: begin
        pending_next      = mot_pend;
        phase_index_next  = mot_phase;
        coil_latch_next   = mot_coil;
        homing_phase_next = hm_hph;
        stepped_next      = mot_stepped;
        init_done_next    = hm_done;
      end
      OP_START: begin
        pending_next[0]   = sat_add(pending[0], START_PRELOAD);
        homing_phase_next = HPH_FIRST;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        pending[m]     <= '0;
        phase_index[m] <= '0;
        coil_latch[m]  <= '0;
      end
      homing_phase <= HPH_IDLE;
      out_valid    <= 1'b0;
      stepped      <= '0;
      init_done    <= 1'b0;
    end else begin
      if (in_xfer) begin
        pending      <= pending_next;
        phase_index  <= phase_index_next;
        coil_latch   <= coil_latch_next;
        homing_phase <= homing_phase_next;
        stepped      <= stepped_next;
        init_done    <= init_done_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // State only changes on an input transfer, so the latches are the result fields.
  assign coils_m1    = coil_latch[0];
  assign coils_m2    = coil_latch[1];
  assign coils_m3    = coil_latch[2];
  assign coils_m4    = coil_latch[3];
  assign homing_busy = (homing_phase != HPH_IDLE);

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && init_done) |-> !homing_busy)
    else $error("init_done reported while homing still runs");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    homing_phase <= HPH_LAST)
    else $error("homing phase out of range");

  a_start_enters: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && op == OP_START) |=> (homing_phase == HPH_FIRST && homing_busy))
    else $error("start item did not enter the first homing phase");

  a_non_tick_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && op != OP_TICK) |=> (stepped == '0 && !init_done))
    else $error("non-tick item drove coils or finished homing");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> ($stable(homing_phase) && $stable(stepped)))
    else $error("state changed while the input was stalled");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the four-motor half-step stepper sequencer and its homing run.
`timescale 1ns / 1ps

module testbench;
  import qhs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 400;
  // Both sides run without idling inside this window; the receiver holds off later on.
  localparam int CALM_START = 120;
  localparam int CALM_END   = 260;
  localparam int HOLD_START = 340;
  localparam int HOLD_LEN   = 80;
  // Half-step coil drive by phase, one nibble per phase, phase 0 in the low nibble.
  localparam logic [31:0] HALF_STEP_SEQ = 32'h98C46231;

  typedef struct packed {
    coil_t      m1;
    coil_t      m2;
    coil_t      m3;
    coil_t      m4;
    logic [3:0] stepped;
    logic       busy;
    logic       done;
  } drive_report_t;

  typedef struct packed {
    logic [1:0]    op;
    mot_id_t       id;
    pend_t         cnt;
    logic [3:0]    sens;
    logic          cancel;
    logic          typed;
    drive_report_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = 2'd0;
  logic [1:0]  motor_id = 2'd0;
  logic signed [15:0] step_count = 16'sd0;
  logic [3:0]  home_sensors = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  coils_m1;
  logic [3:0]  coils_m2;
  logic [3:0]  coils_m3;
  logic [3:0]  coils_m4;
  logic [3:0]  stepped;
  logic        homing_busy;
  logic        init_done;

  int cycle_cnt = 0;
  int rx_cycles = 0;
  int mismatch_count = 0;

  // Predictor state.
  pend_t      pend_model [NUM_MOTORS];
  phase_t     phase_model [NUM_MOTORS];
  coil_t      coil_model [NUM_MOTORS];
  hph_t       home_phase_model;
  logic [3:0] step_mask;

  drive_report_t expected_reports [$];
  stim_row_t     directed_rows [$];
  drive_report_t seen;
  drive_report_t want;

  quad_half_step_stepper_homing i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .motor_id     (motor_id),
    .step_count   (step_count),
    .home_sensors (home_sensors),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coils_m1     (coils_m1),
    .coils_m2     (coils_m2),
    .coils_m3     (coils_m3),
    .coils_m4     (coils_m4),
    .stepped      (stepped),
    .homing_busy  (homing_busy),
    .init_done    (init_done)
  );

  always #5 clk = ~clk;

  function automatic drive_report_t make_report(coil_t c1, coil_t c2, coil_t c3, coil_t c4,
                                                logic [3:0] st, logic busy, logic done);
    drive_report_t r;
    r.m1 = c1;
    r.m2 = c2;
    r.m3 = c3;
    r.m4 = c4;
    r.stepped = st;
    r.busy = busy;
    r.done = done;
    return r;
  endfunction

  // Seek offset once the sensor reads home, or the preload for the next motor.
  function automatic int homing_offset(int k, bit seek);
    case (k)
      0:       return seek ? -160 : 500;
      1:       return seek ? -5450 : 500;
      2:       return seek ? 0 : -500;
      default: return seek ? 200 : 0;
    endcase
  endfunction

  function automatic void queue_steps(int m, int n);
    int s;
    s = int'(pend_model[m]) + n;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    pend_model[m] = pend_t'(s);
  endfunction

  function automatic void fire_coils(int m, bit fwd);
    coil_model[m] = HALF_STEP_SEQ[4 * phase_model[m] +: 4];
    step_mask[m] = 1'b1;
    if (fwd) begin
      phase_model[m] = phase_model[m] + 3'd1;
    end else begin
      phase_model[m] = phase_model[m] - 3'd1;
    end
  endfunction

  function automatic void run_step_pass();
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (pend_model[m] > 0) begin
        fire_coils(m, 1'b1);
        pend_model[m] = pend_model[m] - 16'sd1;
      end else if (pend_model[m] < 0) begin
        fire_coils(m, 1'b0);
        pend_model[m] = pend_model[m] + 16'sd1;
      end
    end
  endfunction

  // Phases are visited in order, so an advance falls through to the next phase at once.
  function automatic bit run_homing_tick(logic [3:0] sens);
    bit finished;
    int k;
    finished = 1'b0;
    for (int p = 1; p <= int'(HPH_LAST); p++) begin
      k = (p - 1) >> 1;
      if (home_phase_model == hph_t'(p)) begin
        if (pend_model[k] != 0) begin
          run_step_pass();
        end else if (p & 1) begin
          if (sens[k]) begin
            fire_coils(k, k == 3);
          end else begin
            home_phase_model = home_phase_model + 4'd1;
            queue_steps(k, homing_offset(k, 1'b1));
          end
        end else if (p == int'(HPH_LAST)) begin
          home_phase_model = HPH_IDLE;
          finished = 1'b1;
        end else begin
          queue_steps(k + 1, homing_offset(k, 1'b0));
          home_phase_model = home_phase_model + 4'd1;
        end
      end
    end
    return finished;
  endfunction

  function automatic drive_report_t predict_outputs(logic [1:0] op_code, mot_id_t mid,
                                                    pend_t cnt, logic [3:0] sens);
    bit finished;
    finished = 1'b0;
    step_mask = 4'd0;
    case (op_code)
      OP_MOVE: queue_steps(int'(mid), int'(cnt));
      OP_TICK: begin
        if (home_phase_model != HPH_IDLE) begin
          finished = run_homing_tick(sens);
        end else begin
          run_step_pass();
        end
      end
      OP_START: begin
        queue_steps(0, int'(START_PRELOAD));
        home_phase_model = HPH_FIRST;
      end
      default: ;
    endcase
    return make_report(coil_model[0], coil_model[1], coil_model[2], coil_model[3],
                       step_mask, home_phase_model != HPH_IDLE, finished);
  endfunction

  // Count that brings a motor's pending steps to zero, or toward it from the low bound.
  function automatic pend_t cancel_count(int m);
    int n;
    n = -int'(pend_model[m]);
    if (n > 32767) n = 32767;
    return pend_t'(n);
  endfunction

  task automatic add_row(logic [1:0] op_code, mot_id_t mid, pend_t cnt, logic [3:0] sens,
                         logic cancel, logic typed, drive_report_t typed_want);
    stim_row_t row;
    row.op = op_code;
    row.id = mid;
    row.cnt = cnt;
    row.sens = sens;
    row.cancel = cancel;
    row.typed = typed;
    row.want = typed_want;
    directed_rows.push_back(row);
  endtask

  // Offers one item, waits for its transfer and records the result it must cause.
  task automatic transfer_item(logic [1:0] op_code, mot_id_t mid, pend_t cnt,
                               logic [3:0] sens, logic typed, drive_report_t typed_want);
    drive_report_t predicted;
    while (!(cycle_cnt >= CALM_START && cycle_cnt < CALM_END) &&
           $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_code;
    motor_id <= mid;
    step_count <= cnt;
    home_sensors <= sens;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_outputs(op_code, mid, cnt, sens);
    expected_reports.push_back(typed ? typed_want : predicted);
  endtask

  task automatic compare_field(string label, logic [3:0] exp_val, logic [3:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s expected %0d got %0d", $time, label, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: random stalls, a calm window, and one long hold-off that backs up the input.
  always @(posedge clk) begin
    if (rst) begin
      rx_cycles <= 0;
      out_stall <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
        out_stall <= 1'b1;
      end else if (rx_cycles >= CALM_START && rx_cycles < CALM_END) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 12);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = make_report(coils_m1, coils_m2, coils_m3, coils_m4, stepped, homing_busy,
                         init_done);
      if (expected_reports.size() == 0) begin
        $display("%0t: result transfer with nothing expected, got %h", $time, seen);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("coils_m1", want.m1, seen.m1);
        compare_field("coils_m2", want.m2, seen.m2);
        compare_field("coils_m3", want.m3, seen.m3);
        compare_field("coils_m4", want.m4, seen.m4);
        compare_field("stepped", want.stepped, seen.stepped);
        compare_field("homing_busy", {3'b000, want.busy}, {3'b000, seen.busy});
        compare_field("init_done", {3'b000, want.done}, {3'b000, seen.done});
      end
    end
  end

  initial begin
    int r;
    int k;
    logic [1:0] op_code;
    mot_id_t mid;
    pend_t cnt;
    logic [3:0] sens;
    stim_row_t row;

    for (int m = 0; m < NUM_MOTORS; m++) begin
      pend_model[m] = '0;
      phase_model[m] = '0;
      coil_model[m] = '0;
    end
    home_phase_model = HPH_IDLE;

    // Extremes and saturation, checked against values read straight off the behavior.
    add_row(OP_UNUSED, 2'd3, 16'sh7FFF, 4'hF, 1'b0, 1'b1, make_report(0, 0, 0, 0, 0, 0, 0));
    add_row(OP_MOVE, 2'd0, 16'sh7FFF, 4'h0, 1'b0, 1'b1, make_report(0, 0, 0, 0, 0, 0, 0));
    add_row(OP_MOVE, 2'd0, 16'sd1, 4'h0, 1'b0, 1'b1, make_report(0, 0, 0, 0, 0, 0, 0));
    add_row(OP_MOVE, 2'd1, 16'sh8000, 4'hF, 1'b0, 1'b1, make_report(0, 0, 0, 0, 0, 0, 0));
    add_row(OP_MOVE, 2'd1, -16'sd1, 4'h0, 1'b0, 1'b1, make_report(0, 0, 0, 0, 0, 0, 0));
    add_row(OP_TICK, 2'd2, 16'sd0, 4'h0, 1'b0, 1'b1,
            make_report(1, 1, 0, 0, 4'b0011, 0, 0));
    add_row(OP_MOVE, 2'd0, 16'sd0, 4'h0, 1'b1, 1'b0, '0);
    add_row(OP_MOVE, 2'd1, 16'sd0, 4'h0, 1'b1, 1'b0, '0);
    // Start, then a restart while homing is already running.
    add_row(OP_START, 2'd0, 16'sd0, 4'h0, 1'b0, 1'b1, make_report(1, 1, 0, 0, 0, 1, 0));
    add_row(OP_START, 2'd3, 16'sd0, 4'hF, 1'b0, 1'b1, make_report(1, 1, 0, 0, 0, 1, 0));
    // A full homing run with the waits cut short by cancelling moves.
    add_row(OP_MOVE, 2'd0, 16'sd0, 4'h0, 1'b1, 1'b0, '0);
    add_row(OP_TICK, 2'd0, 16'sd0, 4'b0001, 1'b0, 1'b0, '0);
    add_row(OP_TICK, 2'd0, 16'sd0, 4'b0000, 1'b0, 1'b0, '0);
    add_row(OP_MOVE, 2'd0, 16'sd0, 4'h0, 1'b1, 1'b0, '0);
    add_row(OP_TICK, 2'd0, 16'sd0, 4'b0000, 1'b0, 1'b0, '0);
    add_row(OP_MOVE, 2'd1, 16'sd0, 4'h0, 1'b1, 1'b0, '0);
    add_row(OP_TICK, 2'd0, 16'sd0, 4'b0000, 1'b0, 1'b0, '0);
    add_row(OP_MOVE, 2'd1, 16'sd0, 4'h0, 1'b1, 1'b0, '0);
    add_row(OP_TICK, 2'd0, 16'sd0, 4'b0100, 1'b0, 1'b0, '0);
    add_row(OP_MOVE, 2'd2, 16'sd0, 4'h0, 1'b1, 1'b0, '0);
    // Seek on motor 3 ends at once and falls through to the preload of motor 4.
    add_row(OP_TICK, 2'd0, 16'sd0, 4'b0000, 1'b0, 1'b0, '0);
    add_row(OP_MOVE, 2'd3, 16'sd0, 4'h0, 1'b1, 1'b0, '0);
    add_row(OP_TICK, 2'd0, 16'sd0, 4'b1000, 1'b0, 1'b0, '0);
    add_row(OP_TICK, 2'd0, 16'sd0, 4'b0000, 1'b0, 1'b0, '0);
    add_row(OP_MOVE, 2'd3, 16'sd0, 4'h0, 1'b1, 1'b0, '0);
    add_row(OP_TICK, 2'd0, 16'sd0, 4'b0000, 1'b0, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      cnt = row.cancel ? cancel_count(int'(row.id)) : row.cnt;
      transfer_item(row.op, row.id, cnt, row.sens, row.typed, row.want);
    end

    // Random part: mostly homing runs pushed forward by cancelling moves, plus noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(99);
      k = (int'(home_phase_model) - 1) >> 1;
      mid = mot_id_t'($urandom_range(3));
      sens = 4'($urandom_range(15));
      cnt = pend_t'($urandom);
      op_code = OP_TICK;
      if (home_phase_model != HPH_IDLE && pend_model[k] != 0 && r < 35) begin
        op_code = OP_MOVE;
        mid = mot_id_t'(k);
        cnt = cancel_count(k);
      end else if (r < 60) begin
        op_code = OP_TICK;
      end else if (r < 85) begin
        op_code = OP_MOVE;
        case ($urandom_range(19))
          0, 1, 2:             cnt = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          3, 4, 5, 6, 7:       cnt = pend_t'($urandom);
          default:             cnt = pend_t'(int'($urandom_range(40)) - 20);
        endcase
      end else if (r < 93) begin
        if (home_phase_model == HPH_IDLE || $urandom_range(3) == 0) op_code = OP_START;
      end else if (r < 97) begin
        op_code = OP_UNUSED;
      end else begin
        op_code = OP_MOVE;
        cnt = cancel_count(int'(mid));
      end
      transfer_item(op_code, mid, cnt, sens, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qhs_pkg.sv
rtl/qhs_homing.sv
rtl/qhs_motor.sv
rtl/quad_half_step_stepper_homing.sv
tb/testbench.sv
